// ----- rtl/fts_pkg.sv -----
package fts_pkg;

    // Field widths
    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 16;
    localparam int EP_W      = ADDR_W + PORT_W;
    localparam int SEC_W     = 32;
    localparam int USEC_W    = 20;
    localparam int TIME_W    = SEC_W + USEC_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = TIME_W;

    // Microseconds per second
    localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

    // Direction of the last stamped packet
    typedef enum logic [1:0] {
        DIR_CLIENT = 2'd0,
        DIR_SERVER = 2'd1,
        DIR_NONE   = 2'd2
    } t_dir;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLOW_SRC     = 3'd0,
        REG_FLOW_DST     = 3'd1,
        REG_FIRST_TIME   = 3'd2,
        REG_CLIENT_GAP   = 3'd3,
        REG_SERVER_GAP   = 3'd4,
        REG_REACTION_GAP = 3'd5,
        REG_RTT_GAP      = 3'd6
    } t_cfg_idx;

    // Configuration register set
    typedef struct packed {
        logic [EP_W-1:0]   flow_src;
        logic [EP_W-1:0]   flow_dst;
        logic [TIME_W-1:0] first_time;
        logic [TIME_W-1:0] client_gap;
        logic [TIME_W-1:0] server_gap;
        logic [TIME_W-1:0] reaction_gap;
        logic [TIME_W-1:0] rtt_gap;
    } t_cfg;

    // Flow match flags
    typedef struct packed {
        logic fwd;
        logic rev;
    } t_match;

endpackage

// ----- rtl/fts_cfg_regs.sv -----
module fts_cfg_regs
    import fts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_FLOW_SRC:     r_cfg.flow_src     <= i_cfg_data[EP_W-1:0];
                REG_FLOW_DST:     r_cfg.flow_dst     <= i_cfg_data[EP_W-1:0];
                REG_FIRST_TIME:   r_cfg.first_time   <= i_cfg_data;
                REG_CLIENT_GAP:   r_cfg.client_gap   <= i_cfg_data;
                REG_SERVER_GAP:   r_cfg.server_gap   <= i_cfg_data;
                REG_REACTION_GAP: r_cfg.reaction_gap <= i_cfg_data;
                REG_RTT_GAP:      r_cfg.rtt_gap      <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

endmodule

// ----- rtl/fts_match.sv -----
module fts_match
    import fts_pkg::*;
(
    input  logic              i_is_ipv4,
    input  logic [EP_W-1:0]   i_src_ep,
    input  logic [EP_W-1:0]   i_dst_ep,
    input  t_cfg              i_cfg,
    output t_match            o_match
);

    // Forward and reverse tuple compare, gated by the IPv4 flag
    always_comb begin
        o_match.fwd = i_is_ipv4 && (i_src_ep == i_cfg.flow_src)
                                && (i_dst_ep == i_cfg.flow_dst);
        o_match.rev = i_is_ipv4 && (i_src_ep == i_cfg.flow_dst)
                                && (i_dst_ep == i_cfg.flow_src);
    end

endmodule

// ----- rtl/fts_stamp.sv -----
module fts_stamp
    import fts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_take,
    input  logic              i_dir_srv,
    output logic [SEC_W-1:0]  o_ts_sec,
    output logic [USEC_W-1:0] o_ts_usec
);

    t_dir              r_dir;
    logic [SEC_W-1:0]  r_prev_sec;
    logic [USEC_W-1:0] r_prev_usec;

    logic [TIME_W-1:0] gap;
    logic [USEC_W:0]   usec_sum;
    logic [USEC_W:0]   usec_adj;
    logic              carry;
    logic [SEC_W-1:0]  n_sec;
    logic [USEC_W-1:0] n_usec;

    // Gap select from previous and current direction
    always_comb begin
        case ({r_dir == DIR_SERVER, i_dir_srv})
            2'b00:   gap = i_cfg.client_gap;
            2'b11:   gap = i_cfg.server_gap;
            2'b10:   gap = i_cfg.reaction_gap;
            default: gap = i_cfg.rtt_gap;
        endcase
    end

    // Advance with a single carry into seconds; the first stamp takes first_time
    always_comb begin
        usec_sum = {1'b0, r_prev_usec} + {1'b0, gap[USEC_W-1:0]};
        carry    = (usec_sum >= {1'b0, USEC_PER_SEC});
        usec_adj = carry ? (usec_sum - {1'b0, USEC_PER_SEC}) : usec_sum;
        if (r_dir != DIR_CLIENT && r_dir != DIR_SERVER) begin
            n_sec  = i_cfg.first_time[TIME_W-1:USEC_W];
            n_usec = i_cfg.first_time[USEC_W-1:0];
        end else begin
            n_sec  = r_prev_sec + gap[TIME_W-1:USEC_W] + SEC_W'(carry);
            n_usec = usec_adj[USEC_W-1:0];
        end
    end

    assign o_ts_sec  = n_sec;
    assign o_ts_usec = n_usec;

    // Flow state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= DIR_NONE;
            r_prev_sec  <= '0;
            r_prev_usec <= '0;
        end else if (i_take) begin
            r_dir       <= i_dir_srv ? DIR_SERVER : DIR_CLIENT;
            r_prev_sec  <= n_sec;
            r_prev_usec <= n_usec;
        end
    end

endmodule

// ----- rtl/flow_timestamp_synthesizer_top.sv -----
// Stamps the packets of one configured flow with synthetic timestamps. One
// header tuple is accepted per cycle while o_stall is low; its result passes
// through the input register, then the result register. A tuple that
// matches the flow in both senses (client and server endpoints equal) holds
// the input register until both of its results are taken, forward first. A
// stalled result holds a matching tuple behind it. Non-IPv4 and non-matching
// tuples produce nothing and leave the input register without waiting on the
// output. Configuration registers are written through the cfg port, which is
// always ready; write them only while the block is idle.
module flow_timestamp_synthesizer_top
    import fts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // Input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_is_ipv4,
    input  logic [ADDR_W-1:0]    i_saddr,
    input  logic [PORT_W-1:0]    i_sport_in,
    input  logic [ADDR_W-1:0]    i_dst_addr,
    input  logic [PORT_W-1:0]    i_dst_port_in,
    // Output channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [SEC_W-1:0]     o_ts_sec,
    output logic [USEC_W-1:0]    o_ts_usec,
    output logic                 o_from_server,
    output logic                 o_last_of_run
);

    t_cfg   cfg;
    t_match match;

    logic              r_in_v;
    logic              r_ph;
    logic              r_is_ipv4;
    logic [EP_W-1:0]   r_src_ep;
    logic [EP_W-1:0]   r_dst_ep;

    logic              r_out_v;
    logic [SEC_W-1:0]  r_ts_sec;
    logic [USEC_W-1:0] r_ts_usec;
    logic              r_from_srv;
    logic              r_last;

    logic              out_free;
    logic              produces;
    logic              cur_srv;
    logic              cur_last;
    logic              emit;
    logic              in_done;
    logic              in_accept;
    logic [SEC_W-1:0]  ts_sec;
    logic [USEC_W-1:0] ts_usec;

    fts_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fts_match u_match (
        .i_is_ipv4 (r_is_ipv4),
        .i_src_ep  (r_src_ep),
        .i_dst_ep  (r_dst_ep),
        .i_cfg     (cfg),
        .o_match   (match)
    );

    fts_stamp u_stamp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_take    (emit),
        .i_dir_srv (cur_srv),
        .o_ts_sec  (ts_sec),
        .o_ts_usec (ts_usec)
    );

    // Stage control; second phase serves the reverse result of a dual match
    always_comb begin
        out_free  = !r_out_v || !i_stall;
        produces  = r_in_v && (match.fwd || match.rev);
        cur_srv   = r_ph || !match.fwd;
        cur_last  = r_ph || !(match.fwd && match.rev);
        emit      = produces && out_free;
        in_done   = r_in_v && (!produces || (out_free && cur_last));
    end

    assign o_stall   = r_in_v && !in_done;
    assign in_accept = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_ph   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_v <= 1'b1;
            end else if (in_done) begin
                r_in_v <= 1'b0;
            end
            if (emit) begin
                r_ph <= !cur_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_is_ipv4 <= i_is_ipv4;
            r_src_ep  <= {i_saddr, i_sport_in};
            r_dst_ep  <= {i_dst_addr, i_dst_port_in};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (emit) begin
            r_out_v <= 1'b1;
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ts_sec   <= ts_sec;
            r_ts_usec  <= ts_usec;
            r_from_srv <= cur_srv;
            r_last     <= cur_last;
        end
    end

    assign o_valid       = r_out_v;
    assign o_ts_sec      = r_ts_sec;
    assign o_ts_usec     = r_ts_usec;
    assign o_from_server = r_from_srv;
    assign o_last_of_run = r_last;

endmodule

// ----- verif/flow_timestamp_synthesizer_top_test.sv -----
module flow_timestamp_synthesizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fts_pkg::*;

    // Index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // One packet header tuple as presented on the input channel
    typedef struct packed {
        logic              ipv4;
        logic [ADDR_W-1:0] saddr;
        logic [PORT_W-1:0] sport;
        logic [ADDR_W-1:0] daddr;
        logic [PORT_W-1:0] dport;
    } t_pkt;

    // One synthetic timestamp as it should leave the block
    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [USEC_W-1:0] usec;
        logic              from_server;
        logic              last_of_run;
    } t_stamp;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data    = '0;
    logic                 i_valid       = 1'b0;
    logic                 o_stall;
    logic                 i_is_ipv4     = 1'b0;
    logic [ADDR_W-1:0]    i_saddr       = '0;
    logic [PORT_W-1:0]    i_sport_in    = '0;
    logic [ADDR_W-1:0]    i_dst_addr    = '0;
    logic [PORT_W-1:0]    i_dst_port_in = '0;
    logic                 o_valid;
    logic                 i_stall       = 1'b0;
    logic [SEC_W-1:0]     o_ts_sec;
    logic [USEC_W-1:0]    o_ts_usec;
    logic                 o_from_server;
    logic                 o_last_of_run;

    flow_timestamp_synthesizer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_is_ipv4     (i_is_ipv4),
        .i_saddr       (i_saddr),
        .i_sport_in    (i_sport_in),
        .i_dst_addr    (i_dst_addr),
        .i_dst_port_in (i_dst_port_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_ts_sec      (o_ts_sec),
        .o_ts_usec     (o_ts_usec),
        .o_from_server (o_from_server),
        .o_last_of_run (o_last_of_run)
    );

    // Shadow of the block: configuration and flow timing state
    t_cfg              cfg_shadow = '0;
    t_dir              last_dir   = DIR_NONE;
    logic [SEC_W-1:0]  last_sec   = '0;
    logic [USEC_W-1:0] last_usec  = '0;

    t_pkt   pending[$];
    t_stamp stamp_q[$];
    t_pkt   cur_pkt;
    t_stamp stamp_want;
    bit     calm       = 1'b0;
    int     gap_left   = 0;
    int     stall_left = 0;
    int     errors     = 0;
    int     n_pkts     = 0;
    int     n_stamps   = 0;
    int     n_rev      = 0;
    int     n_dual     = 0;
    int     n_writes   = 0;

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Add a packed gap to the last stamp, with one carry into seconds at most
    function automatic void advance_by(logic [TIME_W-1:0] gap);
        logic [31:0]      usec;
        logic [SEC_W-1:0] sec;
        usec = 32'(gap[USEC_W-1:0]) + 32'(last_usec);
        sec  = last_sec + gap[TIME_W-1:USEC_W];
        if (usec >= 32'(USEC_PER_SEC)) begin
            usec = usec - 32'(USEC_PER_SEC);
            sec  = sec + SEC_W'(1);
        end
        last_sec  = sec;
        last_usec = usec[USEC_W-1:0];
    endfunction

    // Stamp one matched packet in direction d and queue the result
    function automatic void stamp_one(t_dir d, logic last_one);
        t_stamp s;
        if (last_dir != DIR_CLIENT && last_dir != DIR_SERVER) begin
            last_sec  = cfg_shadow.first_time[TIME_W-1:USEC_W];
            last_usec = cfg_shadow.first_time[USEC_W-1:0];
        end else if (d == DIR_CLIENT) begin
            advance_by(last_dir == DIR_CLIENT ? cfg_shadow.client_gap
                                              : cfg_shadow.reaction_gap);
        end else begin
            advance_by(last_dir == DIR_SERVER ? cfg_shadow.server_gap
                                              : cfg_shadow.rtt_gap);
        end
        last_dir      = d;
        s.sec         = last_sec;
        s.usec        = last_usec;
        s.from_server = (d == DIR_SERVER);
        s.last_of_run = last_one;
        stamp_q.push_back(s);
    endfunction

    // Match an accepted tuple against the flow, forward result first
    function automatic void stamp_packet(t_pkt p);
        logic [EP_W-1:0] src;
        logic [EP_W-1:0] dst;
        logic            fwd;
        logic            rev;
        if (!p.ipv4) return;
        src = {p.saddr, p.sport};
        dst = {p.daddr, p.dport};
        fwd = (src == cfg_shadow.flow_src) && (dst == cfg_shadow.flow_dst);
        rev = (src == cfg_shadow.flow_dst) && (dst == cfg_shadow.flow_src);
        if (fwd) stamp_one(DIR_CLIENT, !rev);
        if (rev) stamp_one(DIR_SERVER, 1'b1);
    endfunction

    function automatic t_pkt mk_pkt(logic v, logic [ADDR_W-1:0] sa, logic [PORT_W-1:0] sp,
                                    logic [ADDR_W-1:0] da, logic [PORT_W-1:0] dp);
        return {v, sa, sp, da, dp};
    endfunction

    // Tuple of the configured flow, client to server or the reverse
    function automatic t_pkt flow_pkt(bit reverse);
        t_pkt p;
        p.ipv4 = 1'b1;
        {p.saddr, p.sport} = reverse ? cfg_shadow.flow_dst : cfg_shadow.flow_src;
        {p.daddr, p.dport} = reverse ? cfg_shadow.flow_src : cfg_shadow.flow_dst;
        return p;
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [USEC_W-1:0] us;
        case ($urandom_range(0, 3))
            0: us = USEC_W'($urandom);
            1: us = USEC_W'($urandom_range(0, 999999));
            2: us = USEC_W'($urandom_range(999000, 999999));
            default: us = '0;
        endcase
        return {SEC_W'($urandom), us};
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.flow_src     = {ADDR_W'($urandom), PORT_W'($urandom)};
        c.flow_dst     = {ADDR_W'($urandom), PORT_W'($urandom)};
        c.first_time   = rand_time();
        c.client_gap   = rand_time();
        c.server_gap   = rand_time();
        c.reaction_gap = rand_time();
        c.rtt_gap      = rand_time();
        return c;
    endfunction

    task automatic note_error(string msg);
        errors++;
        if (errors <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Config write; valid stays high across back-to-back writes
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        n_writes++;
        case (idx)
            REG_FLOW_SRC:     cfg_shadow.flow_src     = data[EP_W-1:0];
            REG_FLOW_DST:     cfg_shadow.flow_dst     = data[EP_W-1:0];
            REG_FIRST_TIME:   cfg_shadow.first_time   = data;
            REG_CLIENT_GAP:   cfg_shadow.client_gap   = data;
            REG_SERVER_GAP:   cfg_shadow.server_gap   = data;
            REG_REACTION_GAP: cfg_shadow.reaction_gap = data;
            REG_RTT_GAP:      cfg_shadow.rtt_gap      = data;
            default: ;
        endcase
    endtask

    // Full register load; flow registers get junk in the unused top bits
    task automatic load_flow(t_cfg c);
        write_reg(REG_UNUSED, CFG_DAT_W'({$urandom, $urandom}));
        write_reg(REG_FLOW_SRC, {4'($urandom), c.flow_src});
        write_reg(REG_FLOW_DST, {4'($urandom), c.flow_dst});
        write_reg(REG_FIRST_TIME, c.first_time);
        write_reg(REG_CLIENT_GAP, c.client_gap);
        write_reg(REG_SERVER_GAP, c.server_gap);
        write_reg(REG_REACTION_GAP, c.reaction_gap);
        write_reg(REG_RTT_GAP, c.rtt_gap);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold off until the sender is empty, every stamp is back and the pipe is clear
    task automatic wait_idle();
        while (pending.size() != 0 || i_valid || stamp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly flow packets in random direction, plus non-IPv4, near misses and noise
    task automatic random_phase(t_cfg c, int n_match, bit quiet);
        t_pkt p;
        int   matched;
        int   r;
        int   bit_idx;
        wait_idle();
        load_flow(c);
        calm    = quiet;
        matched = 0;
        while (matched < n_match) begin
            r = $urandom_range(0, 99);
            p = flow_pkt($urandom_range(0, 1));
            if (r < 75) begin
                matched++;
            end else if (r < 85) begin
                p.ipv4 = 1'b0;
            end else if (r < 95) begin
                bit_idx    = $urandom_range(0, 2 * EP_W - 1);
                p[bit_idx] = ~p[bit_idx];
            end else begin
                p = {1'($urandom), 32'($urandom), 16'($urandom), 32'($urandom),
                     16'($urandom)};
            end
            pending.push_back(p);
        end
    endtask

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Driver: present pending tuples, predict on each accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                stamp_packet(cur_pkt);
                n_pkts++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    cur_pkt       = pending.pop_front();
                    i_valid       <= 1'b1;
                    i_is_ipv4     <= cur_pkt.ipv4;
                    i_saddr       <= cur_pkt.saddr;
                    i_sport_in    <= cur_pkt.sport;
                    i_dst_addr    <= cur_pkt.daddr;
                    i_dst_port_in <= cur_pkt.dport;
                    gap_left      = calm ? 0 : idle_len();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, compare each accepted stamp with the oldest one queued
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (stamp_q.size() == 0) begin
                    note_error($sformatf("unexpected stamp %h.%h dir %b",
                                         o_ts_sec, o_ts_usec, o_from_server));
                end else begin
                    stamp_want = stamp_q.pop_front();
                    n_stamps++;
                    if (stamp_want.from_server) n_rev++;
                    if (!stamp_want.last_of_run) n_dual++;
                    if (o_ts_sec !== stamp_want.sec)
                        note_error($sformatf("ts_sec expected %h got %h",
                                             stamp_want.sec, o_ts_sec));
                    if (o_ts_usec !== stamp_want.usec)
                        note_error($sformatf("ts_usec expected %h got %h",
                                             stamp_want.usec, o_ts_usec));
                    if (o_from_server !== stamp_want.from_server)
                        note_error($sformatf("from_server expected %b got %b",
                                             stamp_want.from_server, o_from_server));
                    if (o_last_of_run !== stamp_want.last_of_run)
                        note_error($sformatf("last_of_run expected %b got %b",
                                             stamp_want.last_of_run, o_last_of_run));
                end
            end
            if (stall_left == 0) stall_left = calm ? 0 : idle_len();
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Main sequence: directed phases, then random phases with fresh settings
    initial begin
        t_cfg c;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: non-IPv4 and non-matching tuples leave the flow untouched
        pending.push_back(mk_pkt(1'b0, '0, '0, '0, '0));
        pending.push_back(mk_pkt(1'b1, 32'h1, '0, '0, '0));
        pending.push_back(mk_pkt(1'b1, '0, '0, '0, 16'hFFFF));

        // Distinct endpoints, first stamp at the very top, every gap choice
        wait_idle();
        c.flow_src     = {32'hC0A8_0001, 16'd1234};
        c.flow_dst     = {32'h0A00_0002, 16'd443};
        c.first_time   = '1;
        c.client_gap   = {32'd1, 20'd1};
        c.server_gap   = {32'd0, 20'd500000};
        c.reaction_gap = {32'd0, 20'hFFFFF};
        c.rtt_gap      = {32'hFFFF_FFFF, 20'd999999};
        load_flow(c);
        pending.push_back(mk_pkt(1'b0, 32'hC0A8_0001, 16'd1234, 32'h0A00_0002, 16'd443));
        pending.push_back(flow_pkt(1'b0));
        pending.push_back(flow_pkt(1'b0));
        pending.push_back(flow_pkt(1'b1));
        pending.push_back(flow_pkt(1'b1));
        pending.push_back(flow_pkt(1'b0));
        pending.push_back(mk_pkt(1'b1, 32'hC0A8_0001, 16'd1234, 32'h0A00_0002, 16'd442));
        pending.push_back(mk_pkt(1'b1, 32'h0A00_0002, 16'd1234, 32'hC0A8_0001, 16'd443));
        pending.push_back(flow_pkt(1'b1));
        pending.push_back(flow_pkt(1'b0));

        // Identical endpoints at all ones, maximum gaps push usec past 20 bits
        wait_idle();
        c.flow_src     = '1;
        c.flow_dst     = '1;
        c.first_time   = '1;
        c.client_gap   = '1;
        c.server_gap   = '1;
        c.reaction_gap = '1;
        c.rtt_gap      = '1;
        load_flow(c);
        pending.push_back(flow_pkt(1'b0));
        pending.push_back(flow_pkt(1'b0));
        pending.push_back(mk_pkt(1'b0, '1, '1, '1, '1));
        pending.push_back(mk_pkt(1'b1, '0, '0, '0, '0));
        pending.push_back(flow_pkt(1'b1));

        // All-zero settings: the zero tuple matches both ways, gaps add nothing
        wait_idle();
        load_flow('0);
        pending.push_back(mk_pkt(1'b1, '0, '0, '0, '0));
        pending.push_back(mk_pkt(1'b0, '0, '0, '0, '0));
        pending.push_back(mk_pkt(1'b1, '0, '0, '0, '0));

        // Random settings; some phases with equal endpoints, extreme gaps or no idling
        for (int ph = 0; ph < 8; ph++) begin
            c = rand_cfg();
            if (ph == 2 || ph == 7) c.flow_dst = c.flow_src;
            if (ph == 4) begin
                c.client_gap   = '1;
                c.server_gap   = '1;
                c.reaction_gap = '1;
                c.rtt_gap      = '1;
            end
            if (ph == 5) begin
                c.client_gap   = '0;
                c.server_gap   = '0;
                c.reaction_gap = '0;
                c.rtt_gap      = '0;
            end
            random_phase(c, 36, ph == 3 || ph == 6);
        end

        wait_idle();
        calm = 1'b0;
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d tuples and %0d config writes over 12 settings;",
                 n_pkts, n_writes);
        $display("%0d stamps checked, %0d reverse, %0d from dual matches, %0d mismatches.",
                 n_stamps, n_rev, n_dual, errors);
        if (errors == 0) begin
            $display("flow_timestamp_synthesizer_top_test OK");
        end else begin
            $display("flow_timestamp_synthesizer_top_test NOT OK");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("flow_timestamp_synthesizer_top_test NOT OK");
        $finish;
    end

endmodule
